>>> rtl/pfsn_pkg.sv
// ----------------------------------------------------------------------------
// pfsn_pkg
// Types, constants and controller encodings for the proposal filter/sort/NMS.
// ----------------------------------------------------------------------------
`default_nettype none

package pfsn_pkg;

  localparam int DEFAULT_TABLE_DEPTH = 256;
  localparam int DEFAULT_OUT_MAX     = 64;

  localparam int COORD_W = 16;
  localparam int SCORE_W = 16;
  localparam int AREA_W  = 33;
  localparam int POS_W   = 18;
  localparam int LIMP_W  = 9;
  localparam int LIMO_W  = 7;

  // +1 pixel in Q.4
  localparam logic [4:0] PIX_ONE = 5'd16;

  typedef enum logic [2:0] {
    REG_MIN_BOX_SIZE      = 3'd0,
    REG_SCORE_THRESHOLD   = 3'd1,
    REG_OVERLAP_THRESHOLD = 3'd2,
    REG_PRE_LIMIT         = 3'd3,
    REG_POST_LIMIT        = 3'd4,
    REG_IMAGE_WIDTH       = 3'd5,
    REG_IMAGE_HEIGHT      = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic [15:0]       min_box_size;
    logic [15:0]       score_threshold;
    logic [15:0]       overlap_threshold;
    logic [LIMP_W-1:0] pre_limit;
    logic [LIMO_W-1:0] post_limit;
    logic [15:0]       image_width;
    logic [15:0]       image_height;
  } cfg_t;

  typedef struct packed {
    logic [COORD_W-1:0] left;
    logic [COORD_W-1:0] top;
    logic [COORD_W-1:0] right;
    logic [COORD_W-1:0] bottom;
    logic [SCORE_W-1:0] score;
    logic [AREA_W-1:0]  area;
  } entry_t;

  typedef enum logic [3:0] {
    S_IDLE, S_FILT, S_AREA, S_SCAN, S_CMP, S_WRITE, S_FIN, S_CLR,
    S_ILOOP, S_IGET, S_JLOOP, S_J1, S_J2, S_J3, S_J4, S_FLUSH
  } ctrl_state_t;

  typedef struct packed {
    logic load;
    logic filt;
    logic area;
    logic rd_pos;
    logic mv_entry;
    logic wr_new;
    logic clr_init;
    logic clr_step;
    logic nms_init;
    logic rd_i;
    logic i_inc;
    logic take;
    logic rd_j;
    logic j_inc;
    logic ov1;
    logic ov2;
    logic ov3;
    logic mark_set;
    logic flush;
  } cmd_t;

  typedef struct packed {
    logic in_valid;
    logic keep;
    logic fin;
    logic pos_zero;
    logic score_lt;
    logic idx_done;
    logic j_done;
    logic k_done;
    logic mark;
    logic pend;
    logic out_full;
  } sts_t;

endpackage

`default_nettype wire

>>> rtl/pfsn_if.sv
// ----------------------------------------------------------------------------
// pfsn_if
// Valid/ready channels for proposal words and result words.
// ----------------------------------------------------------------------------
`default_nettype none

interface proposal_if;
  logic               valid;
  logic               ready;
  logic signed [17:0] center_x;
  logic signed [17:0] center_y;
  logic [17:0]        box_width;
  logic [17:0]        box_height;
  logic [15:0]        objectness;
  logic               final_box;

  modport source (output valid, center_x, center_y, box_width, box_height,
                  objectness, final_box, input ready);
  modport sink   (input valid, center_x, center_y, box_width, box_height,
                  objectness, final_box, output ready);
endinterface

interface result_if;
  logic        valid;
  logic        ready;
  logic        valid_res;
  logic [15:0] left;
  logic [15:0] top;
  logic [15:0] right;
  logic [15:0] bottom;
  logic [15:0] kept_score;
  logic        last;

  modport source (output valid, valid_res, left, top, right, bottom, kept_score,
                  last, input ready);
  modport sink   (input valid, valid_res, left, top, right, bottom, kept_score,
                  last, output ready);
endinterface

`default_nettype wire

>>> rtl/pfsn_cfg.sv
// ----------------------------------------------------------------------------
// pfsn_cfg
// APB register file for the proposal filter/sort/NMS settings.
// ----------------------------------------------------------------------------
`default_nettype none

module pfsn_cfg (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          psel,
  input  wire logic          penable,
  input  wire logic          pwrite,
  input  wire logic [4:0]    paddr,
  input  wire logic [31:0]   pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output pfsn_pkg::cfg_t     cfg
);

  pfsn_pkg::reg_idx_t idx;
  logic               wr;

  assign idx    = pfsn_pkg::reg_idx_t'(paddr[4:2]);
  assign wr     = psel & penable & pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_box_size      <= 16'd256;
      cfg.score_threshold   <= 16'd0;
      cfg.overlap_threshold <= 16'd45875;
      cfg.pre_limit         <= '0;
      cfg.post_limit        <= '0;
      cfg.image_width       <= 16'd0;
      cfg.image_height      <= 16'd0;
    end else if (wr) begin
      case (idx)
        pfsn_pkg::REG_MIN_BOX_SIZE:      cfg.min_box_size      <= pwdata[15:0];
        pfsn_pkg::REG_SCORE_THRESHOLD:   cfg.score_threshold   <= pwdata[15:0];
        pfsn_pkg::REG_OVERLAP_THRESHOLD: cfg.overlap_threshold <= pwdata[15:0];
        pfsn_pkg::REG_PRE_LIMIT:   cfg.pre_limit  <= pwdata[pfsn_pkg::LIMP_W-1:0];
        pfsn_pkg::REG_POST_LIMIT:  cfg.post_limit <= pwdata[pfsn_pkg::LIMO_W-1:0];
        pfsn_pkg::REG_IMAGE_WIDTH:       cfg.image_width       <= pwdata[15:0];
        pfsn_pkg::REG_IMAGE_HEIGHT:      cfg.image_height      <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      pfsn_pkg::REG_MIN_BOX_SIZE:      prdata = {16'd0, cfg.min_box_size};
      pfsn_pkg::REG_SCORE_THRESHOLD:   prdata = {16'd0, cfg.score_threshold};
      pfsn_pkg::REG_OVERLAP_THRESHOLD: prdata = {16'd0, cfg.overlap_threshold};
      pfsn_pkg::REG_PRE_LIMIT:   prdata = {{(32-pfsn_pkg::LIMP_W){1'b0}}, cfg.pre_limit};
      pfsn_pkg::REG_POST_LIMIT:  prdata = {{(32-pfsn_pkg::LIMO_W){1'b0}}, cfg.post_limit};
      pfsn_pkg::REG_IMAGE_WIDTH:       prdata = {16'd0, cfg.image_width};
      pfsn_pkg::REG_IMAGE_HEIGHT:      prdata = {16'd0, cfg.image_height};
      default:                         prdata = 32'd0;
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/pfsn_ctrl.sv
// ----------------------------------------------------------------------------
// pfsn_ctrl
// Sequencer: filter, sorted insertion, mark clear, greedy NMS and emission.
// ----------------------------------------------------------------------------
`default_nettype none

module pfsn_ctrl (
  input  wire logic       clk,
  input  wire logic       rst,
  input  pfsn_pkg::sts_t  sts,
  output pfsn_pkg::cmd_t  cmd,
  output logic            in_ready,
  output logic            idle
);

  pfsn_pkg::ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pfsn_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      pfsn_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (sts.in_valid) begin
          cmd.load   = 1'b1;
          state_next = pfsn_pkg::S_FILT;
        end
      end
      pfsn_pkg::S_FILT: begin
        cmd.filt   = 1'b1;
        state_next = pfsn_pkg::S_AREA;
      end
      pfsn_pkg::S_AREA: begin
        cmd.area   = 1'b1;
        state_next = sts.keep ? pfsn_pkg::S_SCAN : pfsn_pkg::S_FIN;
      end
      pfsn_pkg::S_SCAN: begin
        if (sts.pos_zero) begin
          state_next = pfsn_pkg::S_WRITE;
        end else begin
          cmd.rd_pos = 1'b1;
          state_next = pfsn_pkg::S_CMP;
        end
      end
      pfsn_pkg::S_CMP: begin
        if (sts.score_lt) begin
          cmd.mv_entry = 1'b1;
          state_next   = pfsn_pkg::S_SCAN;
        end else begin
          state_next = pfsn_pkg::S_WRITE;
        end
      end
      pfsn_pkg::S_WRITE: begin
        cmd.wr_new = 1'b1;
        state_next = pfsn_pkg::S_FIN;
      end
      pfsn_pkg::S_FIN: begin
        if (sts.fin) begin
          cmd.clr_init = 1'b1;
          state_next   = pfsn_pkg::S_CLR;
        end else begin
          state_next = pfsn_pkg::S_IDLE;
        end
      end
      pfsn_pkg::S_CLR: begin
        if (sts.idx_done) begin
          cmd.nms_init = 1'b1;
          state_next   = pfsn_pkg::S_ILOOP;
        end else begin
          cmd.clr_step = 1'b1;
        end
      end
      pfsn_pkg::S_ILOOP: begin
        if (sts.idx_done || sts.k_done) begin
          state_next = pfsn_pkg::S_FLUSH;
        end else begin
          cmd.rd_i   = 1'b1;
          state_next = pfsn_pkg::S_IGET;
        end
      end
      pfsn_pkg::S_IGET: begin
        if (sts.mark) begin
          cmd.i_inc  = 1'b1;
          state_next = pfsn_pkg::S_ILOOP;
        end else if (!(sts.pend && sts.out_full)) begin
          cmd.take   = 1'b1;
          state_next = pfsn_pkg::S_JLOOP;
        end
      end
      pfsn_pkg::S_JLOOP: begin
        if (sts.k_done || sts.j_done) begin
          cmd.i_inc  = 1'b1;
          state_next = pfsn_pkg::S_ILOOP;
        end else begin
          cmd.rd_j   = 1'b1;
          state_next = pfsn_pkg::S_J1;
        end
      end
      pfsn_pkg::S_J1: begin
        if (sts.mark) begin
          cmd.j_inc  = 1'b1;
          state_next = pfsn_pkg::S_JLOOP;
        end else begin
          cmd.ov1    = 1'b1;
          state_next = pfsn_pkg::S_J2;
        end
      end
      pfsn_pkg::S_J2: begin
        cmd.ov2    = 1'b1;
        state_next = pfsn_pkg::S_J3;
      end
      pfsn_pkg::S_J3: begin
        cmd.ov3    = 1'b1;
        state_next = pfsn_pkg::S_J4;
      end
      pfsn_pkg::S_J4: begin
        cmd.mark_set = 1'b1;
        state_next   = pfsn_pkg::S_JLOOP;
      end
      pfsn_pkg::S_FLUSH: begin
        if (!sts.out_full) begin
          cmd.flush  = 1'b1;
          state_next = pfsn_pkg::S_IDLE;
        end
      end
      default: state_next = pfsn_pkg::S_IDLE;
    endcase
  end

  assign idle = (state == pfsn_pkg::S_IDLE);

endmodule

`default_nettype wire

>>> rtl/pfsn_dp.sv
// ----------------------------------------------------------------------------
// pfsn_dp
// Datapath: box geometry, sorted box table, mark store, overlap test and
// output register.
// ----------------------------------------------------------------------------
`default_nettype none

module pfsn_dp #(
  parameter int TABLE_DEPTH = pfsn_pkg::DEFAULT_TABLE_DEPTH,
  parameter int OUT_MAX     = pfsn_pkg::DEFAULT_OUT_MAX
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  pfsn_pkg::cfg_t   cfg,
  input  pfsn_pkg::cmd_t   cmd,
  output pfsn_pkg::sts_t   sts,
  proposal_if.sink         proposals,
  result_if.source         results
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int LW = (CW > pfsn_pkg::LIMP_W) ? CW : pfsn_pkg::LIMP_W;
  localparam int KW = pfsn_pkg::LIMO_W;

  // input word
  logic signed [17:0] cx, cy;
  logic [17:0]        bw, bh;
  logic [15:0]        sc;
  logic               fin;

  // new box
  pfsn_pkg::entry_t nb;
  logic             keep;
  logic [16:0]      dx, dy;

  // table and marks
  pfsn_pkg::entry_t mem [TABLE_DEPTH];
  logic             mark_mem [TABLE_DEPTH];
  pfsn_pkg::entry_t rd_q;
  logic             mark_q;
  logic             re, we, mwe, mdata;
  logic [AW-1:0]    raddr, waddr, maddr;
  pfsn_pkg::entry_t wdata;

  // counters
  logic [CW-1:0] count, pos, i, j, lim, n;
  logic [CW:0]   n_inc;
  logic [KW-1:0] k, plim;

  // suppression
  pfsn_pkg::entry_t bi, pend;
  logic             havepend;
  logic [16:0]      ow, oh;
  logic [pfsn_pkg::AREA_W-1:0] aj;
  logic [33:0]      inter;
  logic [49:0]      lhs, rhs;

  // output register
  logic             out_valid, push, out_fire;
  logic             o_vres, o_last;
  pfsn_pkg::entry_t o_box, push_box;
  logic             push_vres, push_last;

  // geometry
  logic signed [19:0] x1, y1, x2, y2;
  logic [15:0]        cl, ct, cr, cb;
  logic [17:0]        rr, bb;
  logic [15:0]        ml, mt, mr, mb;
  logic [33:0]        uni;

  function automatic logic [15:0] clip(input logic signed [19:0] v,
                                       input logic [15:0] hi);
    logic [15:0] res;
    if (v < 0) begin
      res = 16'd0;
    end else if (v > $signed({4'd0, hi})) begin
      res = hi;
    end else begin
      res = v[15:0];
    end
    return res;
  endfunction

  always_comb begin
    if (cfg.pre_limit == '0 || LW'(cfg.pre_limit) > LW'(TABLE_DEPTH)) begin
      lim = CW'(TABLE_DEPTH);
    end else begin
      lim = CW'(cfg.pre_limit);
    end
    if (cfg.post_limit == '0 || cfg.post_limit > KW'(OUT_MAX)) begin
      plim = KW'(OUT_MAX);
    end else begin
      plim = cfg.post_limit;
    end
  end

  assign n     = (count < lim) ? count : lim;
  assign n_inc = {1'b0, n} + 1'b1;

  assign x1 = 20'(cx) - $signed({3'd0, bw[17:1]});
  assign y1 = 20'(cy) - $signed({3'd0, bh[17:1]});
  assign x2 = x1 + $signed({2'd0, bw});
  assign y2 = y1 + $signed({2'd0, bh});
  assign cl = clip(x1, cfg.image_width);
  assign ct = clip(y1, cfg.image_height);
  assign cr = clip(x2, cfg.image_width);
  assign cb = clip(y2, cfg.image_height);

  assign ml = (bi.left > rd_q.left) ? bi.left : rd_q.left;
  assign mt = (bi.top > rd_q.top) ? bi.top : rd_q.top;
  assign mr = (bi.right < rd_q.right) ? bi.right : rd_q.right;
  assign mb = (bi.bottom < rd_q.bottom) ? bi.bottom : rd_q.bottom;
  assign rr = {2'd0, mr} + 18'(pfsn_pkg::PIX_ONE);
  assign bb = {2'd0, mb} + 18'(pfsn_pkg::PIX_ONE);
  assign uni = 34'(bi.area) + 34'(aj) - inter;

  // memory port control
  always_comb begin
    re    = cmd.rd_pos | cmd.rd_i | cmd.rd_j;
    raddr = cmd.rd_pos ? AW'(pos - 1'b1) : (cmd.rd_i ? i[AW-1:0] : j[AW-1:0]);
    we    = (cmd.mv_entry | cmd.wr_new) && (pos < lim);
    waddr = pos[AW-1:0];
    wdata = cmd.mv_entry ? rd_q : nb;
    mwe   = cmd.clr_step | (cmd.mark_set && (lhs >= rhs));
    maddr = cmd.clr_step ? i[AW-1:0] : j[AW-1:0];
    mdata = cmd.mark_set;
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (mwe) begin
      mark_mem[maddr] <= mdata;
    end
    if (re) begin
      rd_q   <= mem[raddr];
      mark_q <= mark_mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cx  <= proposals.center_x;
      cy  <= proposals.center_y;
      bw  <= proposals.box_width;
      bh  <= proposals.box_height;
      sc  <= proposals.objectness;
      fin <= proposals.final_box;
    end
    if (cmd.filt) begin
      keep      <= !(bw < 18'(cfg.min_box_size) || bh < 18'(cfg.min_box_size) ||
                     sc < cfg.score_threshold);
      nb.left   <= cl;
      nb.top    <= ct;
      nb.right  <= cr;
      nb.bottom <= cb;
      nb.score  <= sc;
      dx        <= 17'(cr - cl) + 17'(pfsn_pkg::PIX_ONE);
      dy        <= 17'(cb - ct) + 17'(pfsn_pkg::PIX_ONE);
    end
    if (cmd.area) begin
      nb.area <= pfsn_pkg::AREA_W'(dx * dy);
    end
    if (cmd.take) begin
      bi   <= rd_q;
      pend <= rd_q;
    end
    if (cmd.ov1) begin
      ow <= (rr > {2'd0, ml}) ? 17'(rr - {2'd0, ml}) : 17'd0;
      oh <= (bb > {2'd0, mt}) ? 17'(bb - {2'd0, mt}) : 17'd0;
      aj <= rd_q.area;
    end
    if (cmd.ov2) begin
      inter <= ow * oh;
    end
    if (cmd.ov3) begin
      lhs <= {inter[33:0], 16'd0};
      rhs <= cfg.overlap_threshold * uni;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      havepend <= 1'b0;
      pos      <= '0;
      i        <= '0;
      j        <= '0;
      k        <= '0;
    end else begin
      if (cmd.filt) begin
        pos <= n;
      end
      if (cmd.mv_entry) begin
        pos <= pos - 1'b1;
      end
      if (cmd.wr_new) begin
        if (pos < lim) begin
          count <= (n_inc > {1'b0, lim}) ? lim : n_inc[CW-1:0];
        end else begin
          count <= n;
        end
      end
      if (cmd.clr_init) begin
        i <= '0;
      end
      if (cmd.clr_step || cmd.i_inc) begin
        i <= i + 1'b1;
      end
      if (cmd.nms_init) begin
        i        <= '0;
        k        <= '0;
        havepend <= 1'b0;
      end
      if (cmd.take) begin
        havepend <= 1'b1;
        k        <= k + 1'b1;
        j        <= i + 1'b1;
      end
      if (cmd.j_inc || cmd.mark_set) begin
        j <= j + 1'b1;
      end
      if (cmd.flush) begin
        count    <= '0;
        havepend <= 1'b0;
      end
    end
  end

  // output word
  always_comb begin
    push      = (cmd.take && havepend) || cmd.flush;
    push_box  = pend;
    push_vres = 1'b1;
    push_last = cmd.flush;
    if (cmd.flush && !havepend) begin
      push_box  = '0;
      push_vres = 1'b0;
    end
  end

  assign out_fire = out_valid & results.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (push) begin
      out_valid <= 1'b1;
    end else if (out_fire) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      o_box  <= push_box;
      o_vres <= push_vres;
      o_last <= push_last;
    end
  end

  assign results.valid      = out_valid;
  assign results.valid_res  = o_vres;
  assign results.left       = o_box.left;
  assign results.top        = o_box.top;
  assign results.right      = o_box.right;
  assign results.bottom     = o_box.bottom;
  assign results.kept_score = o_box.score;
  assign results.last       = o_last;

  always_comb begin
    sts.in_valid = proposals.valid;
    sts.keep     = keep;
    sts.fin      = fin;
    sts.pos_zero = (pos == '0);
    sts.score_lt = (rd_q.score < nb.score);
    sts.idx_done = (i >= n);
    sts.j_done   = (j >= n);
    sts.k_done   = (k >= plim);
    sts.mark     = mark_q;
    sts.pend     = havepend;
    sts.out_full = out_valid & ~results.ready;
  end

endmodule

`default_nettype wire

>>> rtl/proposal_filter_sort_nms.sv
// ----------------------------------------------------------------------------
// proposal_filter_sort_nms
// Region proposal filter, descending score sort and greedy NMS.
//
// proposals: one decoded box per word (valid/ready). A word is taken only
// when the block is idle. A dropped word goes straight back to idle; a kept
// word is placed by sorted insertion, which reads each table entry of lower
// score and moves it down one place, starting from the end of the table.
// A word with final_box set then runs suppression: a mark clear over the
// table, then for each unmarked candidate in score order an overlap test
// against every later unmarked entry, marking those that overlap too much;
// already suppressed later entries are skipped.
// results: up to post_limit boxes (OUT_MAX when post_limit is 0 or exceeds
// it), last set on the final one; an image with no kept box gives a single
// word with valid_res 0. A one-word output register holds a result while
// the receiver stalls; suppression waits on it. Reset clears the settings
// to defaults and empties the table. Settings are to be written through the
// APB port only while the block is idle; the block does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

module proposal_filter_sort_nms #(
  parameter int TABLE_DEPTH = pfsn_pkg::DEFAULT_TABLE_DEPTH,
  parameter int OUT_MAX     = pfsn_pkg::DEFAULT_OUT_MAX
) (
  input  wire logic        clk,
  input  wire logic        rst,
  proposal_if.sink         proposals,
  result_if.source         results,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  pfsn_pkg::cfg_t cfg;
  pfsn_pkg::cmd_t cmd;
  pfsn_pkg::sts_t sts;
  logic           idle;

  pfsn_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  pfsn_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .sts      (sts),
    .cmd      (cmd),
    .in_ready (proposals.ready),
    .idle     (idle)
  );

  pfsn_dp #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .OUT_MAX     (OUT_MAX)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd       (cmd),
    .sts       (sts),
    .proposals (proposals),
    .results   (results)
  );

  a_rst_empty: assert property (@(posedge clk) rst |=> !results.valid)
    else $error("result valid after reset");

  a_one_per_idle: assert property (@(posedge clk) disable iff (rst)
    (proposals.valid && proposals.ready) |=> !proposals.ready)
    else $error("word accepted on consecutive cycles");

  a_empty_is_last: assert property (@(posedge clk) disable iff (rst)
    (results.valid && !results.valid_res) |-> results.last)
    else $error("empty result not last");

  a_busy_out: assert property (@(posedge clk) disable iff (rst)
    (results.valid && !results.last) |-> !idle)
    else $error("non-final result pending while idle");

endmodule

`default_nettype wire

>>> tb/proposal_filter_sort_nms_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// proposal_filter_sort_nms_tb
// Self-checking bench for the proposal filter, score sort and NMS block.
// Boxes stream in image by image; a scoreboard class keeps its own sorted
// table and suppression pass, predicts the kept boxes of each image and
// checks every result word in order. Settings change between images over
// APB, once in the middle of an image, with both channels stalling at random.
// ----------------------------------------------------------------------------
module proposal_filter_sort_nms_tb;

  localparam int DEPTH = pfsn_pkg::DEFAULT_TABLE_DEPTH;
  localparam int OMAX  = pfsn_pkg::DEFAULT_OUT_MAX;
  localparam int LIMIT = 1500000;

  typedef struct {
    bit        valid_res;
    bit [15:0] left, top, right, bottom, kept_score;
    bit        last;
  } box_out_t;

  typedef struct {
    bit signed [17:0] cx, cy;
    bit [17:0]        w, h;
    bit [15:0]        s;
    bit               fin;
  } box_in_t;

  class nms_scoreboard;
    bit [15:0] min_size, score_thr, ov_thr, img_w, img_h;
    bit [8:0]  pre_lim;
    bit [6:0]  post_lim;
    bit [15:0] tl[DEPTH], tt[DEPTH], tr[DEPTH], tb[DEPTH], tsc[DEPTH];
    longint    tarea[DEPTH];
    bit        supp[DEPTH];
    int        count;
    box_out_t  pending_boxes[$];
    int        fails, checked;

    function new();
      min_size = 256; score_thr = 0; ov_thr = 45875; pre_lim = 0; post_lim = 0;
      img_w = 0; img_h = 0; count = 0; fails = 0; checked = 0;
    endfunction

    function void set_reg(pfsn_pkg::reg_idx_t idx, bit [31:0] v);
      case (idx)
        pfsn_pkg::REG_MIN_BOX_SIZE:      min_size  = v[15:0];
        pfsn_pkg::REG_SCORE_THRESHOLD:   score_thr = v[15:0];
        pfsn_pkg::REG_OVERLAP_THRESHOLD: ov_thr    = v[15:0];
        pfsn_pkg::REG_PRE_LIMIT:         pre_lim   = v[8:0];
        pfsn_pkg::REG_POST_LIMIT:        post_lim  = v[6:0];
        pfsn_pkg::REG_IMAGE_WIDTH:       img_w     = v[15:0];
        pfsn_pkg::REG_IMAGE_HEIGHT:      img_h     = v[15:0];
        default: ;
      endcase
    endfunction

    function int table_cap();
      return (pre_lim == 0 || pre_lim > DEPTH) ? DEPTH : int'(pre_lim);
    endfunction

    function int clip(int v, int hi);
      if (v < 0) return 0;
      if (v > hi) return hi;
      return v;
    endfunction

    function bit overlapping(int i, int j);
      longint l, t, r, b, wd, ht, inter, uni;
      l = tl[i] > tl[j] ? tl[i] : tl[j];
      t = tt[i] > tt[j] ? tt[i] : tt[j];
      r = tr[i] < tr[j] ? tr[i] : tr[j];
      b = tb[i] < tb[j] ? tb[i] : tb[j];
      wd = (r + 16 > l) ? r + 16 - l : 0;
      ht = (b + 16 > t) ? b + 16 - t : 0;
      inter = wd * ht;
      uni = tarea[i] + tarea[j] - inter;
      return inter * 65536 >= longint'(ov_thr) * uni;
    endfunction

    function void insert(int l, int t, int r, int b, bit [15:0] s);
      int lim, n, p, newn;
      lim = table_cap();
      n = count < lim ? count : lim;
      p = 0;
      while (p < n && tsc[p] >= s) p++;
      if (p >= lim) begin
        count = n;
        return;
      end
      newn = n + 1 > lim ? lim : n + 1;
      for (int k = newn - 1; k > p; k--) begin
        tl[k] = tl[k-1]; tt[k] = tt[k-1]; tr[k] = tr[k-1]; tb[k] = tb[k-1];
        tsc[k] = tsc[k-1]; tarea[k] = tarea[k-1];
      end
      tl[p] = l; tt[p] = t; tr[p] = r; tb[p] = b; tsc[p] = s;
      tarea[p] = longint'(r - l + 16) * longint'(b - t + 16);
      count = newn;
    endfunction

    function void note_input(box_in_t x);
      int x1, y1, n, plim, k;
      box_out_t o;
      if (!(x.w < min_size || x.h < min_size || x.s < score_thr)) begin
        x1 = int'(x.cx) - int'(x.w >> 1);
        y1 = int'(x.cy) - int'(x.h >> 1);
        insert(clip(x1, img_w), clip(y1, img_h), clip(x1 + int'(x.w), img_w),
               clip(y1 + int'(x.h), img_h), x.s);
      end
      if (!x.fin) return;
      n = count < table_cap() ? count : table_cap();
      plim = (post_lim == 0 || post_lim > OMAX) ? OMAX : int'(post_lim);
      for (int i = 0; i < DEPTH; i++) supp[i] = 0;
      k = 0;
      for (int i = 0; i < n && k < plim; i++) begin
        if (supp[i]) continue;
        for (int j = i + 1; j < n; j++)
          if (!supp[j] && overlapping(i, j)) supp[j] = 1;
        o = '{1'b1, tl[i], tt[i], tr[i], tb[i], tsc[i], 1'b0};
        pending_boxes = {pending_boxes, o};
        k++;
      end
      if (k == 0) begin
        o = '{1'b0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0};
        pending_boxes = {pending_boxes, o};
      end
      pending_boxes[$].last = 1;
      count = 0;
    endfunction

    function void cmp(string name, int e, int a);
      if (e != a) begin
        $error("%s: expected %0d, actual %0d", name, e, a);
        fails++;
      end
    endfunction

    function void check_result(box_out_t a);
      box_out_t e;
      checked++;
      if (pending_boxes.size() == 0) begin
        $error("unexpected result word (left %0d, score %0d)", a.left, a.kept_score);
        fails++;
        return;
      end
      e = pending_boxes.pop_front();
      cmp("valid_res", e.valid_res, a.valid_res);
      cmp("left", e.left, a.left);
      cmp("top", e.top, a.top);
      cmp("right", e.right, a.right);
      cmp("bottom", e.bottom, a.bottom);
      cmp("kept_score", e.kept_score, a.kept_score);
      cmp("last", e.last, a.last);
    endfunction
  endclass

  logic        clk = 0;
  logic        rst = 1;
  logic        psel = 0, penable = 0, pwrite = 0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  proposal_if pin();
  result_if   pout();

  proposal_filter_sort_nms uut (
    .clk(clk), .rst(rst), .proposals(pin), .results(pout),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #2 clk = ~clk;

  nms_scoreboard sb = new();
  bit quiet = 0;
  bit hold_req = 0;
  int hold_cnt = 0;
  int cycles = 0;
  int items = 0, images = 0;
  int seed_x[4], seed_y[4];

  initial begin
    pin.valid = 0; pin.center_x = '0; pin.center_y = '0; pin.box_width = '0;
    pin.box_height = '0; pin.objectness = '0; pin.final_box = 0;
    pout.ready = 0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // receiver: random stalls, plus one long hold-off on request
  always @(posedge clk) begin
    if (hold_req) begin
      hold_req = 0;
      hold_cnt = 3000;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      pout.ready <= 0;
    end else begin
      pout.ready <= quiet || ($urandom_range(99) >= 11);
    end
  end

  always @(posedge clk) begin
    box_in_t x;
    box_out_t r;
    if (!rst && pin.valid && pin.ready) begin
      x = '{pin.center_x, pin.center_y, pin.box_width, pin.box_height,
            pin.objectness, pin.final_box};
      sb.note_input(x);
      items++;
    end
    if (!rst && pout.valid && pout.ready) begin
      r = '{pout.valid_res, pout.left, pout.top, pout.right, pout.bottom,
            pout.kept_score, pout.last};
      sb.check_result(r);
    end
  end

  task automatic apb_write(pfsn_pkg::reg_idx_t idx, bit [31:0] v);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= 5'(4 * int'(idx)); pwdata <= v;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    sb.set_reg(idx, v);
    psel <= 0; penable <= 0; pwrite <= 0;
    @(posedge clk);
  endtask

  task automatic send(box_in_t x);
    if (!quiet && $urandom_range(99) < 11) begin
      pin.valid <= 0;
      do @(posedge clk); while ($urandom_range(99) < 11);
    end
    pin.valid <= 1;
    pin.center_x <= x.cx; pin.center_y <= x.cy; pin.box_width <= x.w;
    pin.box_height <= x.h; pin.objectness <= x.s; pin.final_box <= x.fin;
    @(posedge clk);
    while (!pin.ready) @(posedge clk);
    if (x.fin) images++;
  endtask

  task automatic drain(int settle);
    pin.valid <= 0;
    @(posedge clk);
    while (sb.pending_boxes.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  function automatic box_in_t mk(int cx, int cy, int w, int h, int s, bit fin);
    box_in_t x;
    x.cx = 18'(cx); x.cy = 18'(cy); x.w = 18'(w); x.h = 18'(h);
    x.s = 16'(s); x.fin = fin;
    return x;
  endfunction

  function automatic box_in_t cluster_box(bit fin);
    int k;
    int ties[4] = '{1000, 30000, 30000, 65535};
    k = $urandom_range(3);
    return mk(seed_x[k] + $urandom_range(128) - 64, seed_y[k] + $urandom_range(128) - 64,
              $urandom_range(1200, 60), $urandom_range(1200, 60),
              $urandom_range(3) == 0 ? ties[$urandom_range(3)] : $urandom_range(65535), fin);
  endfunction

  function automatic box_in_t noise_box(bit fin);
    return mk($urandom, $urandom, $urandom, $urandom, $urandom, fin);
  endfunction

  task automatic random_settings();
    int v;
    v = $urandom_range(9);
    apb_write(pfsn_pkg::REG_MIN_BOX_SIZE,
              v < 3 ? 0 : v < 8 ? $urandom_range(200) : $urandom_range(65535));
    apb_write(pfsn_pkg::REG_SCORE_THRESHOLD,
              $urandom_range(3) == 0 ? 0 : $urandom_range(25000));
    v = $urandom_range(9);
    apb_write(pfsn_pkg::REG_OVERLAP_THRESHOLD, v == 0 ? 0 : v == 1 ? 65535 : v < 5 ? 45875
                                               : $urandom_range(65535));
    v = $urandom_range(9);
    apb_write(pfsn_pkg::REG_PRE_LIMIT, v == 0 ? 0 : v == 1 ? 256 : $urandom_range(24, 1));
    v = $urandom_range(9);
    apb_write(pfsn_pkg::REG_POST_LIMIT, v == 0 ? 0 : v == 1 ? 127 : $urandom_range(70, 1));
    apb_write(pfsn_pkg::REG_IMAGE_WIDTH, $urandom_range(9) == 0 ? $urandom_range(65535)
                                         : $urandom_range(8000, 500));
    apb_write(pfsn_pkg::REG_IMAGE_HEIGHT, $urandom_range(9) == 0 ? $urandom_range(65535)
                                          : $urandom_range(8000, 500));
    for (int k = 0; k < 4; k++) begin
      seed_x[k] = $urandom_range(sb.img_w);
      seed_y[k] = $urandom_range(sb.img_h);
    end
  endtask

  initial begin
    int n;
    repeat (5) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // reset settings: zero clip bounds, every kept box collapses to a point
    send(mk(100, 100, 300, 300, 500, 0));
    send(mk(-131072, 131071, 262143, 262143, 65535, 0));
    send(mk(131071, -131072, 256, 255, 700, 1));
    // empty image
    send(mk(0, 0, 0, 0, 0, 1));
    drain(40);

    apb_write(pfsn_pkg::REG_MIN_BOX_SIZE, 32'hFFFF_0010);
    apb_write(pfsn_pkg::REG_SCORE_THRESHOLD, 100);
    apb_write(pfsn_pkg::REG_OVERLAP_THRESHOLD, 0);
    apb_write(pfsn_pkg::REG_PRE_LIMIT, 3);
    apb_write(pfsn_pkg::REG_POST_LIMIT, 127);
    apb_write(pfsn_pkg::REG_IMAGE_WIDTH, 65535);
    apb_write(pfsn_pkg::REG_IMAGE_HEIGHT, 65520);
    // full table, ties, below-threshold score, zero overlap threshold
    send(mk(500, 500, 200, 200, 99, 0));
    send(mk(500, 500, 200, 200, 400, 0));
    send(mk(600, 600, 200, 200, 400, 0));
    send(mk(900, 100, 300, 100, 800, 0));
    send(mk(131071, 131071, 262143, 16, 50000, 0));
    send(mk(40, 40, 16, 16, 200, 1));
    drain(40);

    apb_write(pfsn_pkg::REG_OVERLAP_THRESHOLD, 65535);
    apb_write(pfsn_pkg::REG_PRE_LIMIT, 511);
    apb_write(pfsn_pkg::REG_POST_LIMIT, 1);
    send(mk(1000, 1000, 400, 400, 9000, 0));
    send(mk(1000, 1000, 400, 400, 9000, 0));
    send(mk(3000, 2000, 100, 800, 65535, 1));
    drain(40);

    // table limit lowered in the middle of an image
    apb_write(pfsn_pkg::REG_PRE_LIMIT, 0);
    apb_write(pfsn_pkg::REG_POST_LIMIT, 0);
    apb_write(pfsn_pkg::REG_OVERLAP_THRESHOLD, 45875);
    for (int k = 0; k < 5; k++) send(mk(200 * k, 300, 300, 300, 1000 + 100 * k, 0));
    drain(600);
    apb_write(pfsn_pkg::REG_PRE_LIMIT, 2);
    send(mk(700, 700, 500, 500, 1200, 0));
    send(mk(50, 50, 100, 100, 10, 1));
    drain(40);

    while (items < 320) begin
      random_settings();
      n = (images % 9 == 4) ? 40 : $urandom_range(20, 1);
      if (images % 9 == 4) apb_write(pfsn_pkg::REG_PRE_LIMIT, 0);
      quiet = (images == 12);
      for (int k = 0; k < n; k++) begin
        if (images == 18 && k == n - 1) hold_req = 1;
        send($urandom_range(9) == 0 ? noise_box(k == n - 1) : cluster_box(k == n - 1));
      end
      if (images % 3 == 0) drain(40);
      else begin
        // next image follows directly; settings only change once drained
        n = $urandom_range(12, 1);
        for (int k = 0; k < n; k++) send(cluster_box(k == n - 1));
        drain(40);
      end
    end
    quiet = 0;
    drain(100);

    $display("Covered %0d proposals over %0d images, %0d result words checked.",
             items, images, sb.checked);
    if (sb.fails == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
